// ===== sv/hkvt_pkg.sv =====
// ---------------------------------------------------------------------------
// hkvt_pkg
// Shared types and constants for the hashed key-value table.
// ---------------------------------------------------------------------------
package hkvt_pkg;

    localparam logic [63:0] C_MIX1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] C_MIX2 = 64'hc4ceb9fe1a85ec53;
    localparam int          C_SHIFT = 33;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_TAKEN     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_TAKE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE
    } t_bk_state;

endpackage

// ===== sv/hashed_key_value_take_put_table_unit.sv =====
// ---------------------------------------------------------------------------
// hashed_key_value_take_put_table_unit
// Key-value table: fmix64 hash front, two-entry queue, bucket back part.
// ---------------------------------------------------------------------------
// Path from an accepted request to the result on the ports: the split 64-bit
// multiplies and the reduction mod BUCKETS in the hash front, then the queue,
// then the bucket read and write back, which waits while the last result is unpopped.
// The hash front takes one request at a time and takes the next only once its
// bucket has entered the queue; the bucket access overlaps the next request's hash.
// Reset clears all valid marks at once; no clearing pass.
module hashed_key_value_take_put_table_unit #(
    parameter int BUCKETS = 61,
    parameter int WAYS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [63:0] i_key,
    input  logic [31:0] i_put_value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [31:0] o_take_value
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int QW = BW + 97;

    logic          r_op;
    logic [63:0]   r_key;
    logic [31:0]   r_pval;
    logic          w_h_ready, w_h_valid, w_q_full, w_q_empty, w_take;
    logic [BW-1:0] w_bucket;
    logic [QW-1:0] w_q_out;

    assign full = !w_h_ready;

    always_ff @(posedge i_clk) begin
        if (push && w_h_ready) begin
            r_op <= i_op; r_key <= i_key; r_pval <= i_put_value;
        end
    end

    hkvt_hash #(.BUCKETS(BUCKETS), .BW(BW)) u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(push), .o_ready(w_h_ready), .i_key(i_key),
        .o_valid(w_h_valid), .i_ready(!w_q_full), .o_bucket(w_bucket)
    );

    hkvt_fifo #(.DW(QW)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_h_valid), .o_full(w_q_full),
        .i_data({w_bucket, r_op, r_key, r_pval}),
        .i_pop(w_take), .o_empty(w_q_empty), .o_data(w_q_out)
    );

    hkvt_table #(.BUCKETS(BUCKETS), .WAYS(WAYS), .BW(BW)) u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!w_q_empty), .o_take(w_take),
        .i_bucket(w_q_out[QW-1:97]), .i_op(w_q_out[96]),
        .i_key(w_q_out[95:32]), .i_put_value(w_q_out[31:0]),
        .o_empty(empty), .i_pop(pop),
        .o_status(o_status), .o_take_value(o_take_value)
    );

endmodule

// ===== sv/hkvt_hash.sv =====
// ---------------------------------------------------------------------------
// hkvt_hash
// Front part: fmix64 over several cycles, then bucket = hash mod BUCKETS.
// One item at a time; multiplies are split into 32x32 partial products and
// the modulo uses a 16-bit digit fold followed by a reciprocal multiply.
// ---------------------------------------------------------------------------
module hkvt_hash #(
    parameter int BUCKETS = 61,
    parameter int BW      = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [63:0]   i_key,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [BW-1:0] o_bucket
);

    // fold result width, reciprocal shift and width, product width
    localparam int FW = BW + 18;
    localparam int SH = FW + BW;
    localparam int MW = FW + 2;
    localparam int PW = FW + MW;

    localparam logic [63:0]   C_B  = 64'(BUCKETS);
    localparam logic [MW-1:0] C_M  = MW'(((64'd1 << SH) + C_B - 64'd1) / C_B);
    // weights of the 16-bit digits of the hash, mod BUCKETS
    localparam logic [BW-1:0] C_R0 = BW'(64'd1 % C_B);
    localparam logic [BW-1:0] C_R1 = BW'((64'd1 << 16) % C_B);
    localparam logic [BW-1:0] C_R2 = BW'((64'd1 << 32) % C_B);
    localparam logic [BW-1:0] C_R3 = BW'((64'd1 << 48) % C_B);
    localparam logic [FW-1:0] C_BF = FW'(BUCKETS);

    // steps: 0 idle; 1..3 first multiply; 5..7 second multiply;
    // 8 digit fold; 9 reciprocal multiply; 10 quotient times BUCKETS; 11 remainder
    logic [3:0]    r_step;
    logic [63:0]   r_x;
    logic [63:0]   r_acc;
    logic [63:0]   r_rem;
    logic [FW-1:0] r_fold;
    logic [PW-1:0] r_prod;
    logic [FW-1:0] r_qb;
    logic [BW-1:0] r_mod;
    logic          r_done;
    logic [63:0]   w_mul;
    logic [63:0]   w_const;
    logic [31:0]   w_a;
    logic [31:0]   w_b;
    logic [63:0]   w_pp;
    logic [63:0]   w_hash;
    logic [FW-1:0] w_fold;
    logic [FW-1:0] w_quo;

    assign o_ready  = (r_step == 4'd0) && !r_done;
    assign o_valid  = r_done;
    assign o_bucket = r_mod;

    assign w_const = (r_step <= 4'd4) ? hkvt_pkg::C_MIX1 : hkvt_pkg::C_MIX2;
    always_comb begin
        w_a = r_x[31:0];
        w_b = w_const[31:0];
        case (r_step)
            4'd2, 4'd6: begin w_a = r_x[31:0];  w_b = w_const[63:32]; end
            4'd3, 4'd7: begin w_a = r_x[63:32]; w_b = w_const[31:0];  end
            default: begin w_a = r_x[31:0]; w_b = w_const[31:0]; end
        endcase
    end
    assign w_pp   = {32'd0, w_a} * {32'd0, w_b};
    assign w_mul  = (r_step == 4'd1 || r_step == 4'd5) ? w_pp : (r_acc + {w_pp[31:0], 32'd0});
    assign w_hash = w_mul ^ (w_mul >> hkvt_pkg::C_SHIFT);

    assign w_fold = FW'(r_rem[15:0])  * FW'(C_R0) + FW'(r_rem[31:16]) * FW'(C_R1)
                  + FW'(r_rem[47:32]) * FW'(C_R2) + FW'(r_rem[63:48]) * FW'(C_R3);
    assign w_quo  = FW'(r_prod >> SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 4'd0;
            r_done <= 1'b0;
        end else begin
            if (r_done && i_ready) r_done <= 1'b0;
            case (r_step)
                4'd0: if (i_valid && o_ready) begin
                    r_x    <= i_key ^ (i_key >> hkvt_pkg::C_SHIFT);
                    r_step <= 4'd1;
                end
                4'd1, 4'd2, 4'd5, 4'd6: begin
                    r_acc  <= w_mul;
                    r_step <= r_step + 4'd1;
                end
                4'd3: begin
                    r_x    <= w_hash;
                    r_step <= 4'd5;
                end
                4'd7: begin
                    r_rem  <= w_hash;
                    r_step <= 4'd8;
                end
                4'd8: begin
                    r_fold <= w_fold;
                    r_step <= 4'd9;
                end
                4'd9: begin
                    r_prod <= PW'(r_fold) * PW'(C_M);
                    r_step <= 4'd10;
                end
                4'd10: begin
                    r_qb   <= w_quo * C_BF;
                    r_step <= 4'd11;
                end
                4'd11: begin
                    r_mod  <= BW'(r_fold - r_qb);
                    r_step <= 4'd0;
                    r_done <= 1'b1;
                end
                default: r_step <= 4'd0;
            endcase
        end
    end

endmodule

// ===== sv/hkvt_fifo.sv =====
// ---------------------------------------------------------------------------
// hkvt_fifo
// Small two-entry queue between the front and back parts.
// ---------------------------------------------------------------------------
module hkvt_fifo #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== sv/hkvt_table.sv =====
// ---------------------------------------------------------------------------
// hkvt_table
// Back part: bucket read, compare over ways, write back, result register.
// ---------------------------------------------------------------------------
module hkvt_table #(
    parameter int BUCKETS = 61,
    parameter int WAYS    = 4,
    parameter int BW      = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_take,
    input  logic [BW-1:0] i_bucket,
    input  logic          i_op,
    input  logic [63:0]   i_key,
    input  logic [31:0]   i_put_value,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [2:0]    o_status,
    output logic [31:0]   o_take_value
);

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [63:0]     r_key_mem [BUCKETS][WAYS];
    logic [31:0]     r_val_mem [BUCKETS][WAYS];
    logic [WAYS-1:0] r_valid [BUCKETS];

    hkvt_pkg::t_bk_state r_state, n_state;
    logic [BW-1:0]   r_bucket;
    logic            r_op;
    logic [63:0]     r_key;
    logic [31:0]     r_pval;
    logic [63:0]     r_rk [WAYS];
    logic [31:0]     r_rv [WAYS];
    logic [WAYS-1:0] r_rvld;
    logic            r_out_v;
    logic [2:0]      r_status;
    logic [31:0]     r_tval;

    logic            w_hit, w_free;
    logic [WW-1:0]   w_hit_w, w_free_w;
    logic            w_start;
    logic            w_out_free;

    assign w_out_free = !r_out_v || i_pop;
    assign o_empty    = !r_out_v;
    assign o_status   = r_status;
    assign o_take_value = r_tval;

    always_comb begin
        w_hit = 1'b0; w_free = 1'b0; w_hit_w = '0; w_free_w = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rvld[w] && r_rk[w] == r_key) begin
                w_hit = 1'b1; w_hit_w = WW'(w);
            end
            if (!r_rvld[w]) begin
                w_free = 1'b1; w_free_w = WW'(w);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hkvt_pkg::BK_IDLE:  if (i_valid) n_state = hkvt_pkg::BK_READ;
            hkvt_pkg::BK_READ:  n_state = hkvt_pkg::BK_WRITE;
            hkvt_pkg::BK_WRITE: if (w_out_free) n_state = hkvt_pkg::BK_IDLE;
            default:            n_state = hkvt_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        w_start = 1'b0;
        unique case (r_state)
            hkvt_pkg::BK_IDLE: w_start = i_valid;
            default:           w_start = 1'b0;
        endcase
    end
    assign o_take = w_start;

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_bucket <= i_bucket; r_op <= i_op; r_key <= i_key; r_pval <= i_put_value;
        end
        if (r_state == hkvt_pkg::BK_READ) begin
            for (int w = 0; w < WAYS; w++) begin
                r_rk[w] <= r_key_mem[r_bucket][w];
                r_rv[w] <= r_val_mem[r_bucket][w];
            end
            r_rvld <= r_valid[r_bucket];
        end
        if (r_state == hkvt_pkg::BK_WRITE && w_out_free) begin
            if (r_op == hkvt_pkg::OP_PUT && !w_hit && w_free) begin
                r_key_mem[r_bucket][w_free_w] <= r_key;
                r_val_mem[r_bucket][w_free_w] <= r_pval;
            end
            r_tval <= (r_op == hkvt_pkg::OP_TAKE && w_hit) ? r_rv[w_hit_w] : 32'd0;
            if (r_op == hkvt_pkg::OP_PUT)
                r_status <= w_hit ? hkvt_pkg::ST_DUPLICATE :
                            (w_free ? hkvt_pkg::ST_STORED : hkvt_pkg::ST_FULL);
            else
                r_status <= w_hit ? hkvt_pkg::ST_TAKEN : hkvt_pkg::ST_NOT_FOUND;
        end
        if (!i_rst_n) begin
            r_state <= hkvt_pkg::BK_IDLE;
            r_out_v <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) r_valid[b] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == hkvt_pkg::BK_WRITE && w_out_free) begin
                r_out_v <= 1'b1;
                if (r_op == hkvt_pkg::OP_PUT && !w_hit && w_free)
                    r_valid[r_bucket][w_free_w] <= 1'b1;
                if (r_op == hkvt_pkg::OP_TAKE && w_hit)
                    r_valid[r_bucket][w_hit_w] <= 1'b0;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    a_take_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_status != hkvt_pkg::ST_TAKEN |-> r_tval == 32'd0)
        else $error("nonzero value without take");
    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_status <= hkvt_pkg::ST_NOT_FOUND)
        else $error("bad status");
    a_read_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hkvt_pkg::BK_READ |=> r_state == hkvt_pkg::BK_WRITE)
        else $error("read not followed by write");

endmodule
